FILE: src/imsm_pkg.sv
// imsm_pkg: widths, select codes and shared structs for the image MSE/SNR meter.
// No dependencies; every other file of the block imports it.
package imsm_pkg;

   localparam int PIX_W    = 8;
   localparam int SQ_W     = 16;
   localparam int SUM_W    = 40;
   localparam int GSUM_W   = 42;   // sum of three channel sums
   localparam int CNT_W    = 25;
   localparam int DCNT_W   = 27;   // three times the count
   localparam int FRAC_W   = 16;
   localparam int NUM_W    = GSUM_W + FRAC_W;
   localparam int DEN_W    = GSUM_W;
   localparam int MSE_W    = 32;
   localparam int SNR_W    = 48;
   localparam int SEL_W    = 2;
   localparam int QDEPTH   = 2;

   localparam logic [CNT_W-1:0] MAX_PIXELS = 25'd16777216;

   localparam logic [SEL_W-1:0] SEL_GLOBAL = 2'd0;
   localparam logic [SEL_W-1:0] SEL_RED    = 2'd1;
   localparam logic [SEL_W-1:0] SEL_GREEN  = 2'd2;
   localparam logic [SEL_W-1:0] SEL_BLUE   = 2'd3;

   typedef struct packed {
      logic [PIX_W-1:0] orig_red;
      logic [PIX_W-1:0] orig_green;
      logic [PIX_W-1:0] orig_blue;
      logic [PIX_W-1:0] recon_red;
      logic [PIX_W-1:0] recon_green;
      logic [PIX_W-1:0] recon_blue;
      logic             pixel_last;
   } pix_type;

   typedef struct packed {
      logic [SUM_W-1:0] err_red;
      logic [SUM_W-1:0] err_green;
      logic [SUM_W-1:0] err_blue;
      logic [SUM_W-1:0] sig_red;
      logic [SUM_W-1:0] sig_green;
      logic [SUM_W-1:0] sig_blue;
      logic [CNT_W-1:0] count;
   } job_type;

   typedef struct packed {
      logic [SEL_W-1:0] channel_sel;
      logic [MSE_W-1:0] mse_value;
      logic [SNR_W-1:0] snr_ratio;
      logic             snr_saturated;
      logic             result_last;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quo;
   } div_rsp_type;

endpackage

FILE: src/imsm_ifs.sv
// imsm_req_if / imsm_rsp_if: valid/ready channels for pixel pairs and results.
// Depends on imsm_pkg for field widths.
interface imsm_req_if import imsm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] orig_red;
   logic [PIX_W-1:0] orig_green;
   logic [PIX_W-1:0] orig_blue;
   logic [PIX_W-1:0] recon_red;
   logic [PIX_W-1:0] recon_green;
   logic [PIX_W-1:0] recon_blue;
   logic             pixel_last;

   modport source (output valid, orig_red, orig_green, orig_blue, recon_red, recon_green,
                   recon_blue, pixel_last, input ready);
   modport sink   (input valid, orig_red, orig_green, orig_blue, recon_red, recon_green,
                   recon_blue, pixel_last, output ready);
endinterface

interface imsm_rsp_if import imsm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SEL_W-1:0] channel_sel;
   logic [MSE_W-1:0] mse_value;
   logic [SNR_W-1:0] snr_ratio;
   logic             snr_saturated;
   logic             result_last;

   modport source (output valid, channel_sel, mse_value, snr_ratio, snr_saturated,
                   result_last, input ready);
   modport sink   (input valid, channel_sel, mse_value, snr_ratio, snr_saturated,
                   result_last, output ready);
endinterface

FILE: src/imsm_front.sv
// imsm_front: per-pixel squared error / signal accumulation, one beat per cycle
// while q_room. Depends on imsm_pkg; hands a finished image's sums to imsm_queue.
module imsm_front import imsm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    pix_valid,
   input  pix_type pix,
   output logic    pix_ready,
   input  logic    q_room,
   output logic    push,
   output job_type push_job
);

   function automatic logic [SQ_W-1:0] sq_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
      logic [PIX_W-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

   function automatic logic [SQ_W-1:0] sq(input logic [PIX_W-1:0] a);
      return SQ_W'(a) * SQ_W'(a);
   endfunction

   job_type acc_ff, acc_in;
   job_type upd, nxt;
   logic    take, add;

   assign pix_ready = q_room;
   assign take      = pix_valid && pix_ready;
   assign add       = take && (acc_ff.count < MAX_PIXELS);

   always_comb begin
      upd           = acc_ff;
      upd.err_red   = acc_ff.err_red   + SUM_W'(sq_diff(pix.orig_red,   pix.recon_red));
      upd.err_green = acc_ff.err_green + SUM_W'(sq_diff(pix.orig_green, pix.recon_green));
      upd.err_blue  = acc_ff.err_blue  + SUM_W'(sq_diff(pix.orig_blue,  pix.recon_blue));
      upd.sig_red   = acc_ff.sig_red   + SUM_W'(sq(pix.orig_red));
      upd.sig_green = acc_ff.sig_green + SUM_W'(sq(pix.orig_green));
      upd.sig_blue  = acc_ff.sig_blue  + SUM_W'(sq(pix.orig_blue));
      upd.count     = acc_ff.count + 1'b1;
      nxt           = add ? upd : acc_ff;
      // last beat: snapshot goes to the queue, sums restart from zero
      acc_in        = push ? '0 : nxt;
   end

   assign push     = take && pix.pixel_last;
   assign push_job = nxt;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

FILE: src/imsm_queue.sv
// imsm_queue: short FIFO of finished-image sums between front and back.
// Depends on imsm_pkg (job_type, QDEPTH).
module imsm_queue import imsm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    q_room,
   input  logic    pop,
   output logic    q_nonempty,
   output job_type head
);

   localparam int PTR_W = $clog2(QDEPTH);

   job_type            mem_ff [QDEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]     fill_ff, fill_in;

   assign q_room     = (fill_ff != (PTR_W+1)'(QDEPTH));
   assign q_nonempty = (fill_ff != '0);
   assign head       = mem_ff[rd_ff];

   always_comb begin
      wr_in   = push ? wr_ff + 1'b1 : wr_ff;
      rd_in   = pop  ? rd_ff + 1'b1 : rd_ff;
      fill_in = fill_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

FILE: src/imsm_div.sv
// imsm_div: radix-2 restoring divider, one quotient bit per cycle.
// Depends on imsm_pkg (div_req_type, div_rsp_type, NUM_W, DEN_W).
module imsm_div import imsm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type dreq,
   output div_rsp_type drsp
);

   localparam int STEP_W = $clog2(NUM_W);

   logic                busy_ff, busy_in, done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [DEN_W-1:0]    rem_ff, rem_in, den_ff, den_in;
   logic [NUM_W-1:0]    quo_ff, quo_in;
   logic [DEN_W:0]      shifted;
   logic [DEN_W+1:0]    diff;
   logic                ge;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign ge      = !diff[DEN_W+1];

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      done_in = busy_ff && (step_ff == '0) && !dreq.start;
      if (dreq.start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(NUM_W - 1);
         rem_in  = '0;
         quo_in  = dreq.num;
         den_in  = dreq.den;
      end else if (busy_ff) begin
         // dividend shifts out the top, quotient bits shift in below
         rem_in  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], ge};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   assign drsp.done = done_ff;
   assign drsp.quo  = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
   end

endmodule

FILE: src/imsm_back.sv
// imsm_back: per-image sequencer, four measures through the shared divider.
// Depends on imsm_pkg; pops imsm_queue, drives imsm_div, owns the result register.
module imsm_back import imsm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_nonempty,
   input  job_type     q_head,
   output logic        pop,
   output div_req_type dreq,
   input  div_rsp_type drsp,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SETUP    = 3'd1;
   localparam logic [2:0] ST_MSE_GO   = 3'd2;
   localparam logic [2:0] ST_MSE_WAIT = 3'd3;
   localparam logic [2:0] ST_SNR_GO   = 3'd4;
   localparam logic [2:0] ST_SNR_WAIT = 3'd5;
   localparam logic [2:0] ST_OUT      = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [SEL_W-1:0]  sel_ff, sel_in;
   job_type           job_ff, job_in;
   logic [GSUM_W-1:0] e_ff, e_in, s_ff, s_in, e_sel, s_sel;
   logic [DCNT_W-1:0] d_ff, d_in, d_sel;
   logic [MSE_W-1:0]  mse_ff, mse_in;
   logic [SNR_W-1:0]  snr_ff, snr_in;
   logic              sat_ff, sat_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      unique case (sel_ff)
         SEL_GLOBAL: begin
            e_sel = GSUM_W'(job_ff.err_red) + GSUM_W'(job_ff.err_green)
                  + GSUM_W'(job_ff.err_blue);
            s_sel = GSUM_W'(job_ff.sig_red) + GSUM_W'(job_ff.sig_green)
                  + GSUM_W'(job_ff.sig_blue);
            d_sel = DCNT_W'({job_ff.count, 1'b0}) + DCNT_W'(job_ff.count);
         end
         SEL_RED: begin
            e_sel = GSUM_W'(job_ff.err_red);
            s_sel = GSUM_W'(job_ff.sig_red);
            d_sel = DCNT_W'(job_ff.count);
         end
         SEL_GREEN: begin
            e_sel = GSUM_W'(job_ff.err_green);
            s_sel = GSUM_W'(job_ff.sig_green);
            d_sel = DCNT_W'(job_ff.count);
         end
         default: begin
            e_sel = GSUM_W'(job_ff.err_blue);
            s_sel = GSUM_W'(job_ff.sig_blue);
            d_sel = DCNT_W'(job_ff.count);
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      job_in       = job_ff;
      e_in         = e_ff;
      s_in         = s_ff;
      d_in         = d_ff;
      mse_in       = mse_ff;
      snr_in       = snr_ff;
      sat_in       = sat_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop          = 1'b0;
      dreq.start   = 1'b0;
      dreq.num     = {e_ff, FRAC_W'(0)};
      dreq.den     = DEN_W'(d_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (q_nonempty) begin
               pop      = 1'b1;
               job_in   = q_head;
               sel_in   = SEL_GLOBAL;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            e_in     = e_sel;
            s_in     = s_sel;
            d_in     = d_sel;
            state_in = ST_MSE_GO;
         end
         ST_MSE_GO: begin
            if (d_ff == '0) begin
               mse_in   = '0;
               state_in = ST_SNR_GO;
            end else begin
               dreq.start = 1'b1;
               state_in   = ST_MSE_WAIT;
            end
         end
         ST_MSE_WAIT: begin
            if (drsp.done) begin
               mse_in   = (|drsp.quo[NUM_W-1:MSE_W]) ? '1 : drsp.quo[MSE_W-1:0];
               state_in = ST_SNR_GO;
            end
         end
         ST_SNR_GO: begin
            dreq.num = {s_ff, FRAC_W'(0)};
            dreq.den = e_ff;
            if (e_ff == '0) begin
               snr_in   = '1;
               sat_in   = 1'b1;
               state_in = ST_OUT;
            end else begin
               dreq.start = 1'b1;
               state_in   = ST_SNR_WAIT;
            end
         end
         ST_SNR_WAIT: begin
            if (drsp.done) begin
               sat_in   = |drsp.quo[NUM_W-1:SNR_W];
               snr_in   = (|drsp.quo[NUM_W-1:SNR_W]) ? '1 : drsp.quo[SNR_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.channel_sel   = sel_ff;
               rsp_in.mse_value     = mse_ff;
               rsp_in.snr_ratio     = snr_ff;
               rsp_in.snr_saturated = sat_ff;
               rsp_in.result_last   = (sel_ff == SEL_BLUE);
               rsp_valid_in         = 1'b1;
               if (sel_ff == SEL_BLUE) begin
                  state_in = ST_IDLE;
               end else begin
                  sel_in   = sel_ff + 1'b1;
                  state_in = ST_SETUP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
      job_ff <= job_in;
      e_ff   <= e_in;
      s_ff   <= s_in;
      d_ff   <= d_in;
      mse_ff <= mse_in;
      snr_ff <= snr_in;
      sat_ff <= sat_in;
      rsp_ff <= rsp_in;
   end

endmodule

FILE: src/image_mse_snr_meter.sv
// image_mse_snr_meter: MSE and SNR meter for streams of RGB pixel pairs.
// Depends on imsm_pkg, imsm_ifs, imsm_front, imsm_queue, imsm_div, imsm_back.
//
// Usage:
//   req_bus carries one original/reconstructed pixel pair per beat; pixel_last
//   closes an image. rsp_bus then gives four beats: global, red, green, blue,
//   with result_last set on the blue one.
//   Pixels are taken one per cycle. The front accumulates squared error and
//   squared original per channel and, on the last beat, pushes the image's sums
//   into a two-entry queue and starts the next image from zero. req_bus.ready
//   drops only while that queue is full, i.e. with two finished images still
//   waiting for the back end.
//   The back end runs each measure through one shared radix-2 divider: up to
//   two quotients per measure (MSE, then SNR; no SNR division when the error
//   sum is zero), each a launch, the iterations and a handoff, with a setup
//   state before and an output state after. Each image opens with a pop of
//   the queue, and the divider sets the pace of its four results.
//   Results sit in an output register; while rsp_bus.ready is low the back end
//   prepares the next measure and then waits, and the queue keeps taking pixels
//   until it fills. Pixels past 2^24 in one image are dropped from the sums.
//   Reset (synchronous, active high) clears all sums, the queue and the
//   sequencer; no result beat is pending after it.
module image_mse_snr_meter import imsm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   imsm_req_if.sink          req_bus,
   imsm_rsp_if.source        rsp_bus
);

   pix_type     pix;
   logic        q_room, q_nonempty, push, pop, rsp_valid;
   job_type     push_job, head;
   div_req_type dreq;
   div_rsp_type drsp;
   rsp_type     rsp;

   // pack the channel payload into the front's beat
   assign pix.orig_red    = req_bus.orig_red;
   assign pix.orig_green  = req_bus.orig_green;
   assign pix.orig_blue   = req_bus.orig_blue;
   assign pix.recon_red   = req_bus.recon_red;
   assign pix.recon_green = req_bus.recon_green;
   assign pix.recon_blue  = req_bus.recon_blue;
   assign pix.pixel_last  = req_bus.pixel_last;

   imsm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .pix_valid (req_bus.valid),
      .pix       (pix),
      .pix_ready (req_bus.ready),
      .q_room    (q_room),
      .push      (push),
      .push_job  (push_job)
   );

   // decouples the pixel stream from the per-image division work
   imsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .q_room     (q_room),
      .pop        (pop),
      .q_nonempty (q_nonempty),
      .head       (head)
   );

   imsm_div u_div (
      .clock (clock),
      .reset (reset),
      .dreq  (dreq),
      .drsp  (drsp)
   );

   imsm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_nonempty (q_nonempty),
      .q_head     (head),
      .pop        (pop),
      .dreq       (dreq),
      .drsp       (drsp),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_bus.ready),
      .rsp        (rsp)
   );

   assign rsp_bus.valid         = rsp_valid;
   assign rsp_bus.channel_sel   = rsp.channel_sel;
   assign rsp_bus.mse_value     = rsp.mse_value;
   assign rsp_bus.snr_ratio     = rsp.snr_ratio;
   assign rsp_bus.snr_saturated = rsp.snr_saturated;
   assign rsp_bus.result_last   = rsp.result_last;

endmodule

FILE: verif/mse_snr_checker.sv
`timescale 1ns / 100ps
// mse_snr_checker: watches the pixel and result channels of image_mse_snr_meter,
// predicts the four per-image measures and compares every result beat.
// Depends on imsm_pkg and the imsm_req_if / imsm_rsp_if interfaces.
module mse_snr_checker import imsm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   imsm_req_if         req_bus,
   imsm_rsp_if         rsp_bus,
   output int unsigned error_count,
   output int unsigned results_due
);

   localparam int CHANNELS     = 3;
   localparam int CH_RED       = 0;
   localparam int CH_GREEN     = 1;
   localparam int CH_BLUE      = 2;
   localparam int REPORT_LIMIT = 10;

   localparam logic [DCNT_W-1:0] GLOBAL_DIVISOR = 3;
   localparam logic [MSE_W-1:0]  MSE_MAX        = '1;
   localparam logic [SNR_W-1:0]  SNR_MAX        = '1;

   logic [SUM_W-1:0] err_acc [CHANNELS];
   logic [SUM_W-1:0] sig_acc [CHANNELS];
   logic [CNT_W-1:0] pixel_total;
   rsp_type          expected_measures [$];

   task automatic clear_image();
      for (int c = 0; c < CHANNELS; c++) begin
         err_acc[c] = '0;
         sig_acc[c] = '0;
      end
      pixel_total = '0;
   endtask

   // One measure: Q16.16 mean error and saturating Q32.16 signal/error ratio.
   function automatic rsp_type measure(input logic [SEL_W-1:0]  sel,
                                       input logic [GSUM_W-1:0] e_sum,
                                       input logic [GSUM_W-1:0] s_sum,
                                       input logic [DCNT_W-1:0] divisor,
                                       input logic              last);
      logic [NUM_W-1:0] quo;
      rsp_type          r;
      r.channel_sel   = sel;
      r.result_last   = last;
      r.mse_value     = '0;
      r.snr_saturated = 1'b0;
      if (divisor != '0) begin
         quo = {e_sum, {FRAC_W{1'b0}}} / NUM_W'(divisor);
         r.mse_value = (quo > NUM_W'(MSE_MAX)) ? MSE_MAX : quo[MSE_W-1:0];
      end
      if (e_sum == '0) begin
         // no error at all: ratio pinned at full scale
         r.snr_ratio     = SNR_MAX;
         r.snr_saturated = 1'b1;
      end else begin
         quo = {s_sum, {FRAC_W{1'b0}}} / NUM_W'(e_sum);
         if (quo > NUM_W'(SNR_MAX)) begin
            r.snr_ratio     = SNR_MAX;
            r.snr_saturated = 1'b1;
         end else begin
            r.snr_ratio = quo[SNR_W-1:0];
         end
      end
      return r;
   endfunction

   task automatic absorb_pixel(input pix_type px);
      logic [PIX_W-1:0]  orig  [CHANNELS];
      logic [PIX_W-1:0]  recon [CHANNELS];
      logic [PIX_W-1:0]  gap;
      logic [GSUM_W-1:0] e_all;
      logic [GSUM_W-1:0] s_all;
      orig  = '{px.orig_red, px.orig_green, px.orig_blue};
      recon = '{px.recon_red, px.recon_green, px.recon_blue};
      // pixels beyond the cap are dropped from sums and count
      if (pixel_total < MAX_PIXELS) begin
         for (int c = 0; c < CHANNELS; c++) begin
            gap = (orig[c] >= recon[c]) ? orig[c] - recon[c] : recon[c] - orig[c];
            err_acc[c] = err_acc[c] + SUM_W'(gap) * SUM_W'(gap);
            sig_acc[c] = sig_acc[c] + SUM_W'(orig[c]) * SUM_W'(orig[c]);
         end
         pixel_total = pixel_total + 1'b1;
      end
      if (px.pixel_last) begin
         e_all = GSUM_W'(err_acc[CH_RED]) + GSUM_W'(err_acc[CH_GREEN])
               + GSUM_W'(err_acc[CH_BLUE]);
         s_all = GSUM_W'(sig_acc[CH_RED]) + GSUM_W'(sig_acc[CH_GREEN])
               + GSUM_W'(sig_acc[CH_BLUE]);
         expected_measures.push_back(measure(SEL_GLOBAL, e_all, s_all,
                                             DCNT_W'(pixel_total) * GLOBAL_DIVISOR, 1'b0));
         expected_measures.push_back(measure(SEL_RED, GSUM_W'(err_acc[CH_RED]),
                                             GSUM_W'(sig_acc[CH_RED]),
                                             DCNT_W'(pixel_total), 1'b0));
         expected_measures.push_back(measure(SEL_GREEN, GSUM_W'(err_acc[CH_GREEN]),
                                             GSUM_W'(sig_acc[CH_GREEN]),
                                             DCNT_W'(pixel_total), 1'b0));
         expected_measures.push_back(measure(SEL_BLUE, GSUM_W'(err_acc[CH_BLUE]),
                                             GSUM_W'(sig_acc[CH_BLUE]),
                                             DCNT_W'(pixel_total), 1'b1));
         clear_image();
      end
   endtask

   task automatic report_field(input string field, input logic [63:0] want_v,
                               input logic [63:0] got_v);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("%0t mismatch on %s: expected %0h, got %0h", $time, field, want_v, got_v);
   endtask

   task automatic check_measure(input rsp_type got);
      rsp_type want;
      if (expected_measures.size() == 0) begin
         error_count++;
         if (error_count <= REPORT_LIMIT)
            $display("%0t result beat with none pending: sel %0d mse %0h snr %0h",
                     $time, got.channel_sel, got.mse_value, got.snr_ratio);
         return;
      end
      want = expected_measures.pop_front();
      if (got.channel_sel !== want.channel_sel)
         report_field("channel_sel", want.channel_sel, got.channel_sel);
      if (got.mse_value !== want.mse_value)
         report_field("mse_value", want.mse_value, got.mse_value);
      if (got.snr_ratio !== want.snr_ratio)
         report_field("snr_ratio", want.snr_ratio, got.snr_ratio);
      if (got.snr_saturated !== want.snr_saturated)
         report_field("snr_saturated", want.snr_saturated, got.snr_saturated);
      if (got.result_last !== want.result_last)
         report_field("result_last", want.result_last, got.result_last);
   endtask

   // results are checked before the pixel of the same edge is absorbed
   always @(posedge clock) begin
      if (reset) begin
         clear_image();
         expected_measures.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            check_measure({rsp_bus.channel_sel, rsp_bus.mse_value, rsp_bus.snr_ratio,
                           rsp_bus.snr_saturated, rsp_bus.result_last});
         if (req_bus.valid && req_bus.ready)
            absorb_pixel({req_bus.orig_red, req_bus.orig_green, req_bus.orig_blue,
                          req_bus.recon_red, req_bus.recon_green, req_bus.recon_blue,
                          req_bus.pixel_last});
      end
      results_due = expected_measures.size();
   end

endmodule

FILE: verif/tb_image_mse_snr_meter.sv
`timescale 1ns / 100ps
// tb_image_mse_snr_meter: drives pixel pairs and paces result beats for the meter.
// Depends on imsm_pkg, imsm_ifs, the meter RTL and mse_snr_checker.
module tb_image_mse_snr_meter;
   import imsm_pkg::*;

   // Run shape
   localparam int ITEM_TARGET      = 450;   // pixel beats to send in total
   localparam int TAIL_ITEMS       = 60;    // last stretch runs with no idling
   localparam int LONG_HOLD_CYCLES = 2500;  // result side held off, fills the queue
   localparam int DRAIN_CYCLES     = 600;   // one image's full result latency and more

   // How the original/reconstructed values of one pixel are picked
   typedef enum {FILL_ANY, FILL_EXACT, FILL_NEAR, FILL_EXTREME} fill_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        stall_long = 1'b0;   // stimulus asks the result side for a long hold
   logic        tail_phase = 1'b0;   // no idling on either side from here on
   int          pixels_sent = 0;
   int unsigned mismatch_total;
   int unsigned results_due;

   imsm_req_if req_bus ();
   imsm_rsp_if rsp_bus ();

   image_mse_snr_meter u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   mse_snr_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .error_count (mismatch_total),
      .results_due (results_due)
   );

   // 100 MHz
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop, far beyond the slowest legal run (every pixel closing an image,
   // every result beat stalled, every pixel gapped, plus the long hold).
   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic pix_type pixel_pair(input int o_r, input int o_g, input int o_b,
                                          input int r_r, input int r_g, input int r_b,
                                          input logic last);
      pix_type px;
      px.orig_red    = PIX_W'(o_r);
      px.orig_green  = PIX_W'(o_g);
      px.orig_blue   = PIX_W'(o_b);
      px.recon_red   = PIX_W'(r_r);
      px.recon_green = PIX_W'(r_g);
      px.recon_blue  = PIX_W'(r_b);
      px.pixel_last  = last;
      return px;
   endfunction

   function automatic logic [PIX_W-1:0] rail();
      return {PIX_W{1'($urandom_range(0, 1))}};
   endfunction

   function automatic pix_type random_pixel(input fill_kind_type kind);
      pix_type px;
      px.orig_red   = PIX_W'($urandom_range(0, 255));
      px.orig_green = PIX_W'($urandom_range(0, 255));
      px.orig_blue  = PIX_W'($urandom_range(0, 255));
      px.pixel_last = 1'b0;
      unique case (kind)
         FILL_EXACT: begin
            px.recon_red   = px.orig_red;
            px.recon_green = px.orig_green;
            px.recon_blue  = px.orig_blue;
         end
         FILL_NEAR: begin
            // off by at most two, wrapping at the rails now and then
            px.recon_red   = px.orig_red   + PIX_W'($urandom_range(0, 4)) - 8'd2;
            px.recon_green = px.orig_green + PIX_W'($urandom_range(0, 4)) - 8'd2;
            px.recon_blue  = px.orig_blue  + PIX_W'($urandom_range(0, 4)) - 8'd2;
         end
         FILL_EXTREME: begin
            px.orig_red    = rail();
            px.orig_green  = rail();
            px.orig_blue   = rail();
            px.recon_red   = rail();
            px.recon_green = rail();
            px.recon_blue  = rail();
         end
         default: begin
            px.recon_red   = PIX_W'($urandom_range(0, 255));
            px.recon_green = PIX_W'($urandom_range(0, 255));
            px.recon_blue  = PIX_W'($urandom_range(0, 255));
         end
      endcase
      return px;
   endfunction

   // Offer one pixel beat and hold it until accepted. valid stays high on
   // return so back-to-back beats need no second assignment in one step.
   task automatic send_pixel(input pix_type px);
      req_bus.valid       <= 1'b1;
      req_bus.orig_red    <= px.orig_red;
      req_bus.orig_green  <= px.orig_green;
      req_bus.orig_blue   <= px.orig_blue;
      req_bus.recon_red   <= px.recon_red;
      req_bus.recon_green <= px.recon_green;
      req_bus.recon_blue  <= px.recon_blue;
      req_bus.pixel_last  <= px.pixel_last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic idle_req(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Sender pause: drop valid and wait until every pending result is back.
   // One edge first so the checker has seen the last beat.
   task automatic drain_results();
      idle_req(1);
      wait (results_due == 0);
      @(posedge clock);
   endtask

   // One image: n pixels, the last one marked. Exact images give zero error on
   // every channel; mixed ones draw each pixel from the other fills.
   task automatic send_image(input int n, input logic exact);
      pix_type       px;
      fill_kind_type kind;
      int            pick;
      for (int i = 0; i < n; i++) begin
         if (!tail_phase && $urandom_range(0, 7) == 0)
            idle_req($urandom_range(1, 15));
         pick = $urandom_range(0, 9);
         if (exact)
            kind = FILL_EXACT;
         else if (pick < 5)
            kind = FILL_ANY;
         else if (pick < 8)
            kind = FILL_NEAR;
         else
            kind = FILL_EXTREME;
         px = random_pixel(kind);
         px.pixel_last = (i == n - 1);
         send_pixel(px);
      end
   endtask

   // Result side pacing: random stall bursts, ready runs, one long hold on
   // request, and ready held high for the tail.
   initial begin
      rsp_bus.ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (tail_phase) begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end else if (stall_long) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            stall_long = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   // Pixel side: reset, directed images, pressure, random images, end check.
   initial begin
      int len;
      req_bus.valid       <= 1'b0;
      req_bus.orig_red    <= '0;
      req_bus.orig_green  <= '0;
      req_bus.orig_blue   <= '0;
      req_bus.recon_red   <= '0;
      req_bus.recon_green <= '0;
      req_bus.recon_blue  <= '0;
      req_bus.pixel_last  <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed single-pixel images: nothing at all (zero error and zero signal),
      // full-scale error with full signal, full error with no signal, full
      // signal with no error, and one channel exact while the others are off.
      send_pixel(pixel_pair(0, 0, 0, 0, 0, 0, 1'b1));
      send_pixel(pixel_pair(255, 255, 255, 0, 0, 0, 1'b1));
      send_pixel(pixel_pair(0, 0, 0, 255, 255, 255, 1'b1));
      send_pixel(pixel_pair(255, 255, 255, 255, 255, 255, 1'b1));
      send_pixel(pixel_pair(255, 0, 128, 255, 1, 0, 1'b1));
      // Tiny errors against big signals: very high ratios
      send_pixel(pixel_pair(170, 85, 1, 171, 85, 0, 1'b0));
      send_pixel(pixel_pair(85, 170, 254, 85, 171, 255, 1'b0));
      send_pixel(pixel_pair(200, 60, 30, 201, 59, 31, 1'b1));
      // Rails crossing in every combination
      send_pixel(pixel_pair(255, 0, 255, 0, 255, 255, 1'b0));
      send_pixel(pixel_pair(0, 255, 0, 0, 0, 255, 1'b0));
      send_pixel(pixel_pair(255, 255, 0, 255, 0, 0, 1'b0));
      send_pixel(pixel_pair(0, 0, 255, 255, 255, 255, 1'b1));
      drain_results();

      // Long result-side hold while images keep coming: the two-entry queue
      // fills and pixel ready has to drop.
      stall_long = 1'b1;
      repeat (5) send_image($urandom_range(2, 6), 1'b0);
      drain_results();

      while (pixels_sent < ITEM_TARGET) begin
         if (pixels_sent >= ITEM_TARGET - TAIL_ITEMS)
            tail_phase = 1'b1;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 12);
         send_image(len, $urandom_range(0, 5) == 0);
         if (!tail_phase) begin
            if ($urandom_range(0, 14) == 0)
               drain_results();
            else if ($urandom_range(0, 4) == 0)
               idle_req($urandom_range(1, 15));
         end
      end

      idle_req(1);
      wait (results_due == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_total == 0 && results_due == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: sim.f
src/imsm_pkg.sv
src/imsm_ifs.sv
src/imsm_front.sv
src/imsm_queue.sv
src/imsm_div.sv
src/imsm_back.sv
src/image_mse_snr_meter.sv
verif/mse_snr_checker.sv
verif/tb_image_mse_snr_meter.sv
